// ----- src/udp_pdt_pkg.sv -----
// shared types, codes and defaults for the udp port demux table
package udp_pdt_pkg;

	localparam int TABLE_ENTRIES_DEF = 32;

	localparam int PORT_W = 16;
	localparam int HID_W  = 8;
	localparam int LEN_W  = 15;

	localparam logic [1:0] CMD_OPEN   = 2'd0;
	localparam logic [1:0] CMD_CLOSE  = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_ARG   = 3'd1,
		ST_FULL      = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic             set;
		logic             clr;
		status_t          status;
		logic [HID_W-1:0] found;
	} act_t;

endpackage

// ----- src/udp_pdt_cell.sv -----
// one table entry: stored port and handler with its own port compare
module udp_pdt_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr,
	input  logic                          clr,
	input  logic [udp_pdt_pkg::PORT_W-1:0] wr_port,
	input  logic [udp_pdt_pkg::HID_W-1:0]  wr_handler,
	input  logic [udp_pdt_pkg::PORT_W-1:0] match_port,
	output logic                          valid,
	output logic                          hit,
	output logic [udp_pdt_pkg::HID_W-1:0]  handler
);
	import udp_pdt_pkg::*;

	logic              valid_q;
	logic [PORT_W-1:0] port_q;
	logic [HID_W-1:0]  handler_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr) begin
			valid_q <= 1'b1;
		end else if (clr) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			port_q    <= wr_port;
			handler_q <= wr_handler;
		end
	end

	assign valid   = valid_q;
	assign hit     = valid_q && (port_q == match_port);
	assign handler = handler_q;

endmodule

// ----- src/udp_pdt_resolve.sv -----
// command decode, free slot pick and result selection
module udp_pdt_resolve #(
	parameter int TABLE_ENTRIES = udp_pdt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic [1:0]                                 cmd,
	input  logic [udp_pdt_pkg::PORT_W-1:0]             port,
	input  logic [udp_pdt_pkg::HID_W-1:0]              handler_id,
	input  logic [udp_pdt_pkg::LEN_W-1:0]              packet_length,
	input  logic [TABLE_ENTRIES-1:0]                   valid_vec,
	input  logic [TABLE_ENTRIES-1:0]                   hit_vec,
	input  logic [TABLE_ENTRIES-1:0][udp_pdt_pkg::HID_W-1:0] handler_vec,
	output logic [TABLE_ENTRIES-1:0]                   free_oh,
	output udp_pdt_pkg::act_t                          act
);
	import udp_pdt_pkg::*;

	logic [TABLE_ENTRIES-1:0] empty_vec;
	logic [HID_W-1:0]         hit_handler;
	logic                     port_zero;
	logic                     full;
	logic                     any_hit;

	// lowest free entry as a one-hot vector
	assign empty_vec = ~valid_vec;
	assign free_oh   = empty_vec & (~empty_vec + TABLE_ENTRIES'(1));

	always_comb begin
		hit_handler = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit_handler = hit_handler | (handler_vec[i] & {HID_W{hit_vec[i]}});
		end
	end

	assign port_zero = (port == '0);
	assign full      = &valid_vec;
	assign any_hit   = |hit_vec;

	always_comb begin
		act        = '0;
		act.status = ST_BAD_ARG;
		case (cmd)
			CMD_OPEN: begin
				if (!port_zero && handler_id != '0) begin
					if (full) begin
						act.status = ST_FULL;
					end else if (any_hit) begin
						act.status = ST_DUPLICATE;
					end else begin
						act.status = ST_OK;
						act.set    = 1'b1;
					end
				end
			end
			CMD_CLOSE: begin
				if (!port_zero) begin
					if (any_hit) begin
						act.status = ST_OK;
						act.clr    = 1'b1;
					end else begin
						act.status = ST_NOT_FOUND;
					end
				end
			end
			CMD_LOOKUP: begin
				if (!port_zero && packet_length != '0) begin
					if (any_hit) begin
						act.status = ST_OK;
						act.found  = hit_handler;
					end else begin
						act.status = ST_NOT_FOUND;
					end
				end
			end
			default: begin
				act.status = ST_BAD_ARG;
			end
		endcase
	end

endmodule

// ----- src/udp_port_demux_table.sv -----
// udp port demux table: request register, parallel match table, result register
// a request passes the request register, then the result register; done is high for one cycle
// throughput: one request every cycle, busy stays low; a request sees all earlier updates
// the match over all entries and the lowest free slot pick are combinational, between the request and result registers
// reset clears every entry at once and drops any request in flight; no result after reset until a request
// done is a one-cycle strobe, the receiver has no way to stall it
module udp_port_demux_table #(
	parameter int TABLE_ENTRIES = udp_pdt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     cmd,
	input  logic [udp_pdt_pkg::PORT_W-1:0] port,
	input  logic [udp_pdt_pkg::HID_W-1:0]  handler_id,
	input  logic [udp_pdt_pkg::LEN_W-1:0]  packet_length,
	output logic                           done,
	output logic                           success,
	output logic [2:0]                     status,
	output logic [udp_pdt_pkg::HID_W-1:0]  found_handler
);
	import udp_pdt_pkg::*;

	logic              vld_s1;
	logic [1:0]        cmd_s1;
	logic [PORT_W-1:0] port_s1;
	logic [HID_W-1:0]  hid_s1;
	logic [LEN_W-1:0]  len_s1;

	logic                                done_q;
	logic                                success_q;
	status_t                             status_q;
	logic [HID_W-1:0]                    found_q;

	logic [TABLE_ENTRIES-1:0]            valid_vec;
	logic [TABLE_ENTRIES-1:0]            hit_vec;
	logic [TABLE_ENTRIES-1:0]            free_oh;
	logic [TABLE_ENTRIES-1:0][HID_W-1:0] handler_vec;
	act_t                                act;

	assign busy = 1'b0;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1  <= cmd;
			port_s1 <= port;
			hid_s1  <= handler_id;
			len_s1  <= packet_length;
		end
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		udp_pdt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.wr         (vld_s1 && act.set && free_oh[i]),
			.clr        (vld_s1 && act.clr && hit_vec[i]),
			.wr_port    (port_s1),
			.wr_handler (hid_s1),
			.match_port (port_s1),
			.valid      (valid_vec[i]),
			.hit        (hit_vec[i]),
			.handler    (handler_vec[i])
		);
	end

	udp_pdt_resolve #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_resolve (
		.cmd           (cmd_s1),
		.port          (port_s1),
		.handler_id    (hid_s1),
		.packet_length (len_s1),
		.valid_vec     (valid_vec),
		.hit_vec       (hit_vec),
		.handler_vec   (handler_vec),
		.free_oh       (free_oh),
		.act           (act)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			success_q <= (act.status == ST_OK);
			status_q  <= act.status;
			found_q   <= act.found;
		end
	end

	assign done          = done_q;
	assign success       = success_q;
	assign status        = status_q;
	assign found_handler = found_q;

	// a port is held by at most one entry
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("port matches more than one entry");

	a_success_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (success == (status == ST_OK)))
		else $error("success disagrees with status");

	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !success) |-> (found_handler == '0))
		else $error("handler reported on a failed request");

	a_open_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && act.set) |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
		else $error("open did not take exactly one free entry");

endmodule
